// ===== sv/odo_pkg.sv =====
// ----------------------------------------------------------------------------
// odo_pkg: shared types and constants for the planar odometry integrator
// Angle table, fixed-point widths, and the controller/datapath command bus.
// ----------------------------------------------------------------------------
package odo_pkg;

  // CORDIC iteration count and arctangent table (2^32 units per turn)
  localparam int CORDIC_STEPS  = 16;
  localparam int AngleTableLen = 24;
  localparam int NumSteps      = (CORDIC_STEPS < AngleTableLen) ? CORDIC_STEPS : AngleTableLen;
  localparam int StepW         = $clog2(AngleTableLen);

  localparam logic [31:0] ATAN_TABLE [AngleTableLen] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Datapath widths: vector in Q.24 with CORDIC growth, residual angle, products
  localparam int VecW   = 36;
  localparam int AngW   = 33;
  localparam int OpBW   = 17;
  localparam int ProdW  = VecW + OpBW;
  localparam int DeltaW = ProdW - 24;
  localparam int PosW   = 32;

  // CORDIC gain 0.607253 in Q0.16
  localparam logic signed [OpBW-1:0] GainQ16 = 17'sd39797;

  typedef logic [StepW-1:0] step_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  load;     // capture input beat, pre-rotate
    logic  rot;      // one CORDIC iteration
    step_t step;     // iteration index
    logic  gain_x;   // product <= x * gain
    logic  gain_y;   // product <= y * gain, latch scaled x
    logic  scale_x;  // product <= gx * dt, latch scaled y
    logic  scale_y;  // product <= gy * dt, accumulate x
    logic  acc_y;    // accumulate y
    logic  put;      // load output register
  } odo_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register empty or draining this cycle
  } odo_sts_t;

endpackage

// ===== sv/planar_odometry_integrator.sv =====
// ----------------------------------------------------------------------------
// planar_odometry_integrator: dead-reckoning position integrator
// Rotates body velocity into the world frame and integrates it over time.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one beat per odometry sample carrying body velocities,
//   absolute yaw and elapsed time. Output stream (m_*): one beat per sample
//   with the updated world x/y positions (Q16.16, saturating) and a
//   standing-still flag.
//   Sequence: an accepted sample runs through the iterative CORDIC rotator,
//   then through the gain x/y and time scale x/y steps on the single shared
//   multiplier and the accumulators, then through the hand-off step. The result
//   beat becomes valid in the same cycle as s_tready returns, so a new sample
//   is taken only after the previous one has been handed off; the rotator
//   iteration count sets the sample rate.
//   The output register holds a finished beat, so the next sample is taken
//   while it waits; if m_tready stays low the second sample is held at the
//   hand-off step until the register drains.
//   Reset (rst, synchronous) clears both position accumulators to zero and
//   drops any pending sample and output beat.
// ----------------------------------------------------------------------------
module planar_odometry_integrator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // vel_x[15:0], vel_y[31:16], yaw[47:32], elapsed[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // pos_x[31:0], pos_y[63:32], standing_still[64], zero pad
);
  import odo_pkg::*;

  odo_cmd_t cmd;
  odo_sts_t sts;

  odo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  odo_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sv/odo_ctrl.sv =====
// ----------------------------------------------------------------------------
// odo_ctrl: sequencing controller
// Steps one sample through CORDIC rotation, gain and time scaling,
// accumulation and the output hand-off.
// ----------------------------------------------------------------------------
module odo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  odo_pkg::odo_sts_t sts,
  output odo_pkg::odo_cmd_t cmd
);
  import odo_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_ROT     = 8'b0000_0010,
    S_GAIN_X  = 8'b0000_0100,
    S_GAIN_Y  = 8'b0000_1000,
    S_SCALE_X = 8'b0001_0000,
    S_SCALE_Y = 8'b0010_0000,
    S_ACC_Y   = 8'b0100_0000,
    S_PUT     = 8'b1000_0000
  } state_t;

  localparam step_t LastStep = step_t'(NumSteps - 1);

  state_t state, state_next;
  step_t  step, step_next;

  assign s_tready = (state == S_IDLE);

  // Next state and iteration counter
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (s_tvalid) state_next = S_ROT;
      end
      S_ROT: begin
        step_next = step + 1'b1;
        if (step == LastStep) state_next = S_GAIN_X;
      end
      S_GAIN_X:  state_next = S_GAIN_Y;
      S_GAIN_Y:  state_next = S_SCALE_X;
      S_SCALE_X: state_next = S_SCALE_Y;
      S_SCALE_Y: state_next = S_ACC_Y;
      S_ACC_Y:   state_next = S_PUT;
      S_PUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Command decode
  always_comb begin
    cmd         = '0;
    cmd.load    = (state == S_IDLE) && s_tvalid;
    cmd.rot     = (state == S_ROT);
    cmd.step    = step;
    cmd.gain_x  = (state == S_GAIN_X);
    cmd.gain_y  = (state == S_GAIN_Y);
    cmd.scale_x = (state == S_SCALE_X);
    cmd.scale_y = (state == S_SCALE_Y);
    cmd.acc_y   = (state == S_ACC_Y);
    cmd.put     = (state == S_PUT) && sts.out_free;
  end

  // Checks
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_ROT) && (step == '0))
    else $error("accepted beat did not start rotation");
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (step <= LastStep))
    else $error("CORDIC step index out of range");
  a_put_free: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> $past(sts.out_free))
    else $error("output loaded while occupied");

endmodule

// ===== sv/odo_dp.sv =====
// ----------------------------------------------------------------------------
// odo_dp: odometry datapath
// CORDIC vector rotation, shared multiplier for gain and time scaling,
// saturating position accumulators and the output register.
// ----------------------------------------------------------------------------
module odo_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       s_tdata,
  input  odo_pkg::odo_cmd_t cmd,
  output odo_pkg::odo_sts_t sts,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata
);
  import odo_pkg::*;

  logic signed [VecW-1:0]   x, y, gx, gy;
  logic signed [AngW-1:0]   z;
  logic        [15:0]       dt;
  logic                     still;
  logic signed [PosW-1:0]   acc_x, acc_y;
  logic signed [ProdW-1:0]  prod;

  // Input unpack and quadrant fold
  logic signed [15:0]       vx, vy;
  logic        [15:0]       yaw;
  logic                     flip;
  logic signed [VecW-1:0]   x0, y0;
  logic        [31:0]       ang;

  assign vx   = s_tdata[15:0];
  assign vy   = s_tdata[31:16];
  assign yaw  = s_tdata[47:32];
  assign flip = yaw[15] ^ yaw[14];
  assign x0   = {{(VecW-32){vx[15]}}, vx, 16'b0};
  assign y0   = {{(VecW-32){vy[15]}}, vy, 16'b0};
  assign ang  = {yaw[15] ^ flip, yaw[14:0], 16'b0};

  // CORDIC iteration
  logic signed [VecW-1:0] xs, ys;
  logic signed [AngW-1:0] atan_step;

  assign xs        = x >>> cmd.step;
  assign ys        = y >>> cmd.step;
  assign atan_step = signed'({1'b0, ATAN_TABLE[cmd.step]});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x     <= flip ? -x0 : x0;
      y     <= flip ? -y0 : y0;
      z     <= {ang[31], ang};
      dt    <= s_tdata[63:48];
      still <= (vx == '0) && (vy == '0) && (yaw == '0);
    end else if (cmd.rot) begin
      if (!z[AngW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_step;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_step;
      end
    end
  end

  // Shared multiplier, registered product
  logic signed [VecW-1:0]  mul_a;
  logic signed [OpBW-1:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;

  always_comb begin
    if (cmd.gain_x)       mul_a = x;
    else if (cmd.gain_y)  mul_a = y;
    else if (cmd.scale_x) mul_a = gx;
    else                  mul_a = gy;
    mul_b = (cmd.gain_x || cmd.gain_y) ? GainQ16 : signed'({1'b0, dt});
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.gain_x || cmd.gain_y || cmd.scale_x || cmd.scale_y) prod <= mul_p;
  end

  // Rounding of the product: gain back to Q.24 velocity, time scaling to Q16.16
  logic signed [ProdW-1:0]  gsum, dsum;
  logic signed [VecW-1:0]   g_rnd;
  logic signed [DeltaW-1:0] delta;

  assign gsum  = prod + ProdW'(32768);
  assign g_rnd = gsum[VecW+15:16];
  assign dsum  = prod + ProdW'(8388608);
  assign delta = dsum[ProdW-1:24];

  always_ff @(posedge clk) begin
    if (cmd.gain_y)  gx <= g_rnd;
    if (cmd.scale_x) gy <= g_rnd;
  end

  // Saturating add of the position delta; overflow when the top three bits differ
  function automatic logic signed [PosW-1:0] sat_add(logic signed [PosW-1:0] a,
                                                     logic signed [DeltaW-1:0] d);
    logic signed [PosW+1:0] s;
    s = {{2{a[PosW-1]}}, a} + {{(PosW+2-DeltaW){d[DeltaW-1]}}, d};
    if (!s[PosW+1] && (s[PosW] || s[PosW-1]))      sat_add = {1'b0, {(PosW-1){1'b1}}};
    else if (s[PosW+1] && !(s[PosW] && s[PosW-1])) sat_add = {1'b1, {(PosW-1){1'b0}}};
    else                                           sat_add = s[PosW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x <= '0;
      acc_y <= '0;
    end else begin
      if (cmd.scale_y) acc_x <= sat_add(acc_x, delta);
      if (cmd.acc_y)   acc_y <= sat_add(acc_y, delta);
    end
  end

  // Output register
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.put) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put) m_tdata <= {7'b0, still, acc_y, acc_x};
  end

endmodule
